FILE: sv/mpsws_pkg.sv
// ============================================================================
// Multi-pattern sync word scanner package
// Shared sizes, action codes and state encoding.
// ============================================================================
`default_nettype none

package mpsws_pkg;

    localparam int NUM_PATTERNS = 32;
    localparam int WINDOW_BYTES = 4;
    localparam int NUM_BANKS    = 4;
    localparam int BANK_SIZE    = 256;
    localparam int BANK_AW      = 8;

    localparam logic [2:0] ACT_SCAN         = 3'd0;
    localparam logic [2:0] ACT_SET          = 3'd1;
    localparam logic [2:0] ACT_ALLOW        = 3'd2;
    localparam logic [2:0] ACT_DENY         = 3'd3;
    localparam logic [2:0] ACT_CLEAR_PAT    = 3'd4;
    localparam logic [2:0] ACT_CLEAR_ALL    = 3'd5;
    localparam logic [2:0] ACT_WINDOW_RESET = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_SWEEP  = 3'b100
    } state_t;

    typedef logic [NUM_PATTERNS-1:0] pat_vec_t;

endpackage

`default_nettype wire

FILE: sv/mpsws_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ============================================================================
`default_nettype none

module mpsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/multi_pattern_sync_word_scanner_top.sv
// ============================================================================
// Multi-pattern sync word scanner
// Four 256-entry bank memories hold one bit per pattern for every byte value
// at every window position; scans AND four lookups, edits sweep the banks.
// ============================================================================
// Scan request: one bank read per bank; the result is registered in the lookup state.
// Window reset, unused code and rejected index: result in the cycle after acceptance.
// Set, allow, deny, clear pattern and clear all: a read-modify-write sweep of
// all 256 rows (four banks in parallel), then the result.
// Busy is low while a result is shown, so the next request can be taken then.
// After reset the block is busy while it clears the banks.
`default_nettype none

module multi_pattern_sync_word_scanner_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [5:0]  pattern_index,
    input  wire logic [31:0] sync_word,
    input  wire logic [31:0] sync_mask,
    input  wire logic [7:0]  data_byte,
    output logic             done,
    output logic             status,
    output logic             sync_found,
    output logic [31:0]      match_flags,
    output logic [31:0]      window_bytes,
    output logic             window_full
);

    localparam int NB = mpsws_pkg::NUM_BANKS;
    localparam int AW = mpsws_pkg::BANK_AW;

    mpsws_pkg::state_t state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    logic [AW:0]      addr_reg, addr_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    logic             report_reg, report_next;
    logic [31:0]      window_reg, window_next;
    logic [2:0]       fill_reg, fill_next;
    logic             done_reg, done_next;

    mpsws_pkg::pat_vec_t bit_reg, bit_next;
    logic [31:0]         word_reg, word_next;
    logic [31:0]         mask_reg, mask_next;
    logic                status_reg, status_next;
    logic                found_reg, found_next;
    logic [31:0]         flags_reg, flags_next;
    logic [31:0]         wout_reg, wout_next;
    logic                full_reg, full_next;

    logic                accept;
    logic                idx_ok;
    logic [31:0]         shifted;
    logic [2:0]          fill_inc;
    logic                ram_re;
    logic                ram_we;
    logic [AW-1:0]       ram_raddr [NB];
    mpsws_pkg::pat_vec_t ram_rdata [NB];
    mpsws_pkg::pat_vec_t ram_wdata [NB];
    mpsws_pkg::pat_vec_t lookup_and;
    logic [63:0]         flags_wide;

    assign accept  = start && (state_reg == mpsws_pkg::ST_IDLE);
    assign idx_ok  = 7'(pattern_index) < 7'(mpsws_pkg::NUM_PATTERNS);
    assign shifted = {window_reg[23:0], data_byte};
    assign fill_inc = (fill_reg < 3'(mpsws_pkg::WINDOW_BYTES)) ? fill_reg + 3'd1 : fill_reg;

    assign ram_re = (accept && (action == mpsws_pkg::ACT_SCAN))
                 || ((state_reg == mpsws_pkg::ST_SWEEP) && !addr_reg[AW]);
    assign ram_we = (state_reg == mpsws_pkg::ST_SWEEP) && pend_reg;

    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            if (state_reg == mpsws_pkg::ST_SWEEP)
            begin
                ram_raddr[b] = addr_reg[AW-1:0];
            end
            else
            begin
                ram_raddr[b] = shifted[31-8*b -: 8];
            end
        end
    end

    always_comb
    begin
        logic [7:0] sb;
        logic [7:0] mb;
        logic       hit;
        logic       en;
        for (int b = 0; b < NB; b++)
        begin
            sb  = word_reg[31-8*b -: 8];
            mb  = mask_reg[31-8*b -: 8];
            hit = ((sb ^ pend_addr_reg) & mb) == 8'd0;
            en  = mb != 8'd0;
            case (op_reg)
                mpsws_pkg::ACT_SET:
                begin
                    ram_wdata[b] = hit ? (ram_rdata[b] | bit_reg) : (ram_rdata[b] & ~bit_reg);
                end
                mpsws_pkg::ACT_ALLOW:
                begin
                    ram_wdata[b] = (en && hit) ? (ram_rdata[b] | bit_reg) : ram_rdata[b];
                end
                mpsws_pkg::ACT_DENY:
                begin
                    ram_wdata[b] = (en && hit) ? (ram_rdata[b] & ~bit_reg) : ram_rdata[b];
                end
                mpsws_pkg::ACT_CLEAR_PAT:
                begin
                    ram_wdata[b] = ram_rdata[b] & ~bit_reg;
                end
                default:
                begin
                    ram_wdata[b] = '0;
                end
            endcase
        end
    end

    for (genvar g = 0; g < NB; g++)
    begin : g_bank
        mpsws_ram #(
            .WIDTH (mpsws_pkg::NUM_PATTERNS),
            .DEPTH (mpsws_pkg::BANK_SIZE)
        ) u_bank (
            .clk   (clk),
            .we    (ram_we),
            .waddr (pend_addr_reg),
            .wdata (ram_wdata[g]),
            .re    (ram_re),
            .raddr (ram_raddr[g]),
            .rdata (ram_rdata[g])
        );
    end

    assign lookup_and = ram_rdata[0] & ram_rdata[1] & ram_rdata[2] & ram_rdata[3];
    assign flags_wide = 64'(lookup_and);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = addr_reg[AW-1:0];
        report_next    = report_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        done_next      = 1'b0;
        bit_next       = bit_reg;
        word_next      = word_reg;
        mask_next      = mask_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        flags_next     = flags_reg;
        wout_next      = wout_reg;
        full_next      = full_reg;

        unique case (state_reg)
            mpsws_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    status_next = 1'b0;
                    found_next  = 1'b0;
                    flags_next  = '0;
                    wout_next   = window_reg;
                    full_next   = fill_reg >= 3'(mpsws_pkg::WINDOW_BYTES);
                    bit_next    = mpsws_pkg::pat_vec_t'(1) << pattern_index;
                    word_next   = sync_word;
                    mask_next   = sync_mask;
                    op_next     = action;
                    addr_next   = '0;
                    report_next = 1'b1;
                    case (action)
                        mpsws_pkg::ACT_SCAN:
                        begin
                            window_next = shifted;
                            fill_next   = fill_inc;
                            state_next  = mpsws_pkg::ST_LOOKUP;
                        end
                        mpsws_pkg::ACT_SET, mpsws_pkg::ACT_ALLOW, mpsws_pkg::ACT_DENY,
                        mpsws_pkg::ACT_CLEAR_PAT:
                        begin
                            if (idx_ok)
                            begin
                                state_next = mpsws_pkg::ST_SWEEP;
                            end
                            else
                            begin
                                status_next = 1'b1;
                                done_next   = 1'b1;
                            end
                        end
                        mpsws_pkg::ACT_CLEAR_ALL:
                        begin
                            state_next = mpsws_pkg::ST_SWEEP;
                        end
                        mpsws_pkg::ACT_WINDOW_RESET:
                        begin
                            fill_next = '0;
                            full_next = 1'b0;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            mpsws_pkg::ST_LOOKUP:
            begin
                wout_next  = window_reg;
                full_next  = fill_reg >= 3'(mpsws_pkg::WINDOW_BYTES);
                flags_next = full_next ? flags_wide[31:0] : '0;
                found_next = full_next && (lookup_and != '0);
                done_next  = 1'b1;
                state_next = mpsws_pkg::ST_IDLE;
            end
            mpsws_pkg::ST_SWEEP:
            begin
                if (!addr_reg[AW])
                begin
                    pend_next = 1'b1;
                    addr_next = addr_reg + (AW+1)'(1);
                end
                else if (!pend_reg)
                begin
                    done_next  = report_reg;
                    state_next = mpsws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpsws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpsws_pkg::ST_SWEEP;
            op_reg        <= mpsws_pkg::ACT_CLEAR_ALL;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            report_reg    <= 1'b0;
            window_reg    <= '0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            report_reg    <= report_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg    <= bit_next;
        word_reg   <= word_next;
        mask_reg   <= mask_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        flags_reg  <= flags_next;
        wout_reg   <= wout_next;
        full_reg   <= full_next;
    end

    assign busy         = state_reg != mpsws_pkg::ST_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign sync_found   = found_reg;
    assign match_flags  = flags_reg;
    assign window_bytes = wout_reg;
    assign window_full  = full_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == mpsws_pkg::ST_IDLE))
        else $error("result strobe while a request is still in progress");

    a_write_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == mpsws_pkg::ST_SWEEP))
        else $error("bank write outside a table sweep");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 3'(mpsws_pkg::WINDOW_BYTES))
        else $error("window fill count out of range");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request produced neither work nor a result");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> $past(ram_re))
        else $error("bank write without the matching read");

endmodule

`default_nettype wire
